[rtl/ale_pkg.sv]
// Shared types, sizes and codes for the ordered list engine.
// Has no dependencies; every other file in rtl/ imports it.
`default_nettype none
package ale_pkg;

  localparam int CAPACITY  = 16;
  localparam int WORD_BITS = 32;
  localparam int IDX_BITS  = $clog2(CAPACITY);
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [IDX_BITS-1:0]         idx_t;
  typedef logic [CNT_BITS-1:0]         cnt_t;
  typedef logic [3:0]                  pos_t;

  typedef enum logic [2:0] {
    FN_APPEND = 3'd0,
    FN_DELETE = 3'd1,
    FN_WRITE  = 3'd2,
    FN_SEARCH = 3'd3,
    FN_CLEAR  = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Broadcast from the top level to every cell in the accepting cycle.
  typedef struct packed {
    logic  do_append;
    logic  do_delete;
    logic  do_write;
    logic  do_search;
    word_t word;
    pos_t  position;
    pos_t  start_index;
    cnt_t  count;
  } ale_ctrl_t;

  // Handed from the first stage to the result stage.
  typedef struct packed {
    logic    valid;
    logic    is_search;
    status_t status;
    cnt_t    count;
  } ale_stage_t;

endpackage
`default_nettype wire

[rtl/ale_cell.sv]
// One storage cell of the list: holds a single entry and its search hit flag.
// Depends on ale_pkg.
`default_nettype none
module ale_cell (
  input  wire                    clk,
  input  wire ale_pkg::ale_ctrl_t ctrl,
  input  wire ale_pkg::idx_t      idx,
  input  wire ale_pkg::word_t     next_entry,
  output ale_pkg::word_t          entry,
  output logic                    hit
);
  import ale_pkg::*;

  cnt_t idx_c;
  cnt_t pos_c;
  cnt_t start_c;
  logic below_count;

  assign idx_c       = cnt_t'(idx);
  assign pos_c       = cnt_t'(ctrl.position);
  assign start_c     = cnt_t'(ctrl.start_index);
  assign below_count = idx_c < ctrl.count;

  // Delete pulls the right-hand neighbor down into every cell from the
  // deleted position up to the one before the last live entry.
  always_ff @(posedge clk) begin
    if (ctrl.do_append && (idx_c == ctrl.count)) begin
      entry <= ctrl.word;
    end else if (ctrl.do_write && (idx_c == pos_c)) begin
      entry <= ctrl.word;
    end else if (ctrl.do_delete && (idx_c >= pos_c) && ((idx_c + cnt_t'(1)) < ctrl.count)) begin
      entry <= next_entry;
    end
  end

  always_ff @(posedge clk) begin
    hit <= ctrl.do_search && below_count && (idx_c >= start_c) && (entry == ctrl.word);
  end

endmodule
`default_nettype wire

[rtl/ale_result.sv]
// Result stage: picks the first hit of the cell row and registers the result beat.
// Depends on ale_pkg.
`default_nettype none
module ale_result (
  input  wire                       clk,
  input  wire                       rst,
  input  wire ale_pkg::ale_stage_t  stage,
  input  wire [ale_pkg::CAPACITY-1:0] hits,
  output logic                      done,
  output logic [1:0]                status,
  output logic [3:0]                found_index,
  output logic [4:0]                item_count,
  output logic                      is_empty,
  output logic                      is_full
);
  import ale_pkg::*;

  idx_t    first;
  logic    any_hit;
  status_t status_next;

  always_comb begin
    first = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hits[i]) begin
        first = idx_t'(i);
      end
    end
  end

  assign any_hit = |hits;

  always_comb begin
    if (stage.is_search) begin
      status_next = any_hit ? ST_OK : ST_NOT_FOUND;
    end else begin
      status_next = stage.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    status      <= status_next;
    found_index <= (stage.is_search && any_hit) ? 4'(first) : 4'd0;
    item_count  <= 5'(stage.count);
    is_empty    <= stage.count == '0;
    is_full     <= stage.count == cnt_t'(CAPACITY);
  end

  // A failed search never reports a match position.
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_NOT_FOUND) |-> found_index == 4'd0)
    else $error("not-found result carries a nonzero index");

  // Empty and full flags agree with the reported count.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_empty == (item_count == 5'd0)) && !(is_empty && is_full))
    else $error("empty/full flags disagree with count");

  // Every stage beat becomes exactly one result beat.
  a_beat: assert property (@(posedge clk) disable iff (rst)
    stage.valid |=> done)
    else $error("result beat lost");

endmodule
`default_nettype wire

[rtl/array_list_engine.sv]
// Ordered list engine: a row of sixteen cells, one per entry, plus a result stage.
// The result beat shows on done from the result register, after the stage register.
// Throughput: one command per cycle; busy stays low, since delete shifts every cell
// at once and search compares every cell at once.
// Reset (rst, synchronous) empties the list and drops any command in flight;
// the receiver cannot stall, so each result is on the ports for one cycle only.
`default_nettype none
module array_list_engine (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  output logic              busy,
  input  wire  [2:0]        func,
  input  wire  [3:0]        position,
  input  wire signed [31:0] value,
  input  wire  [3:0]        start_index,
  output logic              done,
  output logic [1:0]        status,
  output logic [3:0]        found_index,
  output logic [4:0]        item_count,
  output logic              is_empty,
  output logic              is_full
);
  import ale_pkg::*;

  // The list itself lives in the cells; only the fill count is kept here.
  cnt_t       fill_count;
  cnt_t       fill_count_next;
  logic       accept;
  func_t      op;
  logic       pos_ok;
  logic       has_room;
  status_t    status_pre;
  ale_ctrl_t  ctrl;
  ale_stage_t stage;
  ale_stage_t stage_next;
  word_t      entries [CAPACITY];
  logic [CAPACITY-1:0] hits;

  // Every command finishes its cell update in the cycle it is taken, so the
  // engine can always take another one.
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign op     = func_t'(func);

  assign pos_ok   = cnt_t'(position) < fill_count;
  assign has_room = fill_count < cnt_t'(CAPACITY);

  // Decode the command into the broadcast that all cells see. The stored word
  // is the input value sign-extended or truncated to the entry width.
  always_comb begin
    ctrl             = '0;
    ctrl.word        = word_t'(value);
    ctrl.position    = position;
    ctrl.start_index = start_index;
    ctrl.count       = fill_count;
    fill_count_next  = fill_count;
    status_pre       = ST_OK;
    if (accept) begin
      case (op)
        FN_APPEND: begin
          if (has_room) begin
            ctrl.do_append  = 1'b1;
            fill_count_next = fill_count + cnt_t'(1);
          end else begin
            status_pre = ST_FULL;
          end
        end
        FN_DELETE: begin
          if (pos_ok) begin
            ctrl.do_delete  = 1'b1;
            fill_count_next = fill_count - cnt_t'(1);
          end else begin
            status_pre = ST_BAD_POS;
          end
        end
        FN_WRITE: begin
          if (pos_ok) begin
            ctrl.do_write = 1'b1;
          end else begin
            status_pre = ST_BAD_POS;
          end
        end
        FN_SEARCH: begin
          ctrl.do_search = 1'b1;
        end
        FN_CLEAR: begin
          fill_count_next = '0;
        end
        default: begin
          status_pre = ST_OK;
        end
      endcase
    end
  end

  always_comb begin
    stage_next.valid     = accept;
    stage_next.is_search = accept && (op == FN_SEARCH);
    stage_next.status    = status_pre;
    stage_next.count     = fill_count_next;
  end

  // Only the fill count and the stage valid bit need a reset; the rest of the
  // stage is qualified by the valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count  <= '0;
      stage.valid <= 1'b0;
    end else begin
      fill_count  <= fill_count_next;
      stage.valid <= stage_next.valid;
    end
    stage.is_search <= stage_next.is_search;
    stage.status    <= stage_next.status;
    stage.count     <= stage_next.count;
  end

  // The cell row. Each cell sees its right-hand neighbor for the delete shift;
  // the last cell never shifts, so it is handed its own entry.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    word_t right;
    if (g == CAPACITY - 1) begin : g_last
      assign right = entries[g];
    end else begin : g_mid
      assign right = entries[g+1];
    end
    ale_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (idx_t'(g)),
      .next_entry (right),
      .entry      (entries[g]),
      .hit        (hits[g])
    );
  end

  ale_result u_result (
    .clk         (clk),
    .rst         (rst),
    .stage       (stage),
    .hits        (hits),
    .done        (done),
    .status      (status),
    .found_index (found_index),
    .item_count  (item_count),
    .is_empty    (is_empty),
    .is_full     (is_full)
  );

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= cnt_t'(CAPACITY))
    else $error("fill count beyond capacity");

  // A taken command produces its result beat through the stage and result registers.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 done)
    else $error("result beat missing");

  // A successful append grows the list by one entry.
  a_append: assert property (@(posedge clk) disable iff (rst)
    accept && (op == FN_APPEND) && has_room |=> fill_count == $past(fill_count) + cnt_t'(1))
    else $error("append did not grow the list");

endmodule
`default_nettype wire

[dv/array_list_engine_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for array_list_engine, the bounded ordered list of signed words.
// Drives commands in random bursts, predicts each result beat with a behavioral list model,
// and compares field by field. Depends on rtl/ale_pkg.sv and rtl/array_list_engine.sv.
module array_list_engine_tb;
  import ale_pkg::*;

  // Func codes with no operation behind them. The block must leave the list alone
  // and answer with status ok.
  localparam logic [2:0] FN_RESERVED_LO = 3'd5;
  localparam logic [2:0] FN_RESERVED_HI = 3'd7;

  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};

  // Cycles with neither a command beat nor a result beat before the run is declared hung.
  // The longest legal quiet stretch is a sender gap plus the delay of the result beat.
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_OPS  = 1850;
  localparam int MAX_LOGGED  = 100;

  // One predicted result beat.
  typedef struct {
    status_t status;
    idx_t    found;
    cnt_t    count;
    logic    empty;
    logic    full;
  } outcome_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [2:0]        func;
  logic [3:0]        position;
  logic signed [31:0] value;
  logic [3:0]        start_index;
  logic              done;
  logic [1:0]        status;
  logic [3:0]        found_index;
  logic [4:0]        item_count;
  logic              is_empty;
  logic              is_full;

  array_list_engine dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .position    (position),
    .value       (value),
    .start_index (start_index),
    .done        (done),
    .status      (status),
    .found_index (found_index),
    .item_count  (item_count),
    .is_empty    (is_empty),
    .is_full     (is_full)
  );

  // Shadow copy of the list as the block should hold it after every accepted command.
  word_t    shadow_list [CAPACITY];
  int       shadow_len;

  // Predicted beats, oldest first, waiting for the block to produce them.
  outcome_t awaited_outcomes [$];

  int mismatches;
  int beats_seen;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one command to the shadow list and returns the beat it should produce.
  // Only entries below the fill count are ever read, so stale words left behind by
  // delete or clear never leak into a prediction.
  function automatic outcome_t apply_list_op(input logic [2:0] fn, input pos_t pos,
                                             input word_t val, input pos_t from);
    outcome_t res;
    res.status = ST_OK;
    res.found  = '0;
    case (fn)
      FN_APPEND: begin
        if (shadow_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          shadow_list[shadow_len] = val;
          shadow_len++;
        end
      end
      FN_DELETE: begin
        if (pos >= shadow_len) begin
          res.status = ST_BAD_POS;
        end else begin
          // Close the gap: every later entry moves down by one.
          for (int i = pos; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      FN_WRITE: begin
        if (pos >= shadow_len) res.status = ST_BAD_POS;
        else shadow_list[pos] = val;
      end
      FN_SEARCH: begin
        // The first match at or after the start index wins; a start beyond the
        // fill count examines nothing.
        res.status = ST_NOT_FOUND;
        for (int i = from; i < shadow_len; i++) begin
          if (shadow_list[i] == val) begin
            res.status = ST_OK;
            res.found  = idx_t'(i);
            break;
          end
        end
      end
      FN_CLEAR: begin
        shadow_len = 0;
      end
      default: begin
      end
    endcase
    res.count = cnt_t'(shadow_len);
    res.empty = (shadow_len == 0);
    res.full  = (shadow_len == CAPACITY);
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_LOGGED) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Presents one command and holds it until the block takes it. Start is left high
  // on return so that a following command goes out back to back; between commands, only
  // a sender gap lowers it. After the beat, the sender either keeps its burst going or pauses.
  task automatic send_op(input logic [2:0] fn, input pos_t pos, input word_t val,
                         input pos_t from);
    int gap;
    start       <= 1'b1;
    func        <= fn;
    position    <= pos;
    value       <= val;
    start_index <= from;
    do @(posedge clk); while (busy);
    awaited_outcomes.push_back(apply_list_op(fn, pos, val, from));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // A quarter of the burst boundaries carry no gap, which strings bursts into
      // long stretches of one command per cycle.
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 24);
    end
  endtask

  // Every result beat is compared with the oldest prediction. The receiver cannot
  // hold results off, so done alone marks the beat.
  always @(posedge clk) begin : result_check
    outcome_t want;
    if (!rst && done) begin
      beats_seen++;
      if (awaited_outcomes.size() == 0) begin
        flag_mismatch($sformatf("result beat %0d with no command outstanding", beats_seen));
      end else begin
        want = awaited_outcomes.pop_front();
        if (status !== want.status)
          flag_mismatch($sformatf("beat %0d status %0d, expected %0d",
                                  beats_seen, status, want.status));
        if (found_index !== want.found)
          flag_mismatch($sformatf("beat %0d found_index %0d, expected %0d",
                                  beats_seen, found_index, want.found));
        if (item_count !== want.count)
          flag_mismatch($sformatf("beat %0d item_count %0d, expected %0d",
                                  beats_seen, item_count, want.count));
        if (is_empty !== want.empty)
          flag_mismatch($sformatf("beat %0d is_empty %b, expected %b",
                                  beats_seen, is_empty, want.empty));
        if (is_full !== want.full)
          flag_mismatch($sformatf("beat %0d is_full %b, expected %b",
                                  beats_seen, is_full, want.full));
      end
    end
  end

  // Hang detector: any cycle that moves a beat in either direction resets the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || done) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Commands against an empty list, plus two of the func codes that do nothing.
  task automatic test_empty_list_ops();
    send_op(FN_CLEAR,       4'd0,  word_t'(0),  4'd0);
    send_op(FN_DELETE,      4'd0,  word_t'(0),  4'd0);
    send_op(FN_WRITE,       4'd15, WORD_MAX,    4'd0);
    send_op(FN_SEARCH,      4'd0,  word_t'(0),  4'd0);
    send_op(FN_RESERVED_LO, 4'd15, word_t'(-1), 4'd15);
    send_op(FN_RESERVED_HI, 4'd0,  WORD_MIN,    4'd0);
  endtask

  // Fills the list from empty to capacity with the extreme words and a duplicate,
  // then appends once more, which must be refused with status full.
  task automatic test_fill_to_capacity();
    send_op(FN_APPEND, 4'd0, WORD_MIN,    4'd0);
    send_op(FN_APPEND, 4'd0, WORD_MAX,    4'd0);
    send_op(FN_APPEND, 4'd0, word_t'(0),  4'd0);
    send_op(FN_APPEND, 4'd0, word_t'(-1), 4'd0);
    for (int k = 4; k < CAPACITY; k++) begin
      if (k == 9) send_op(FN_APPEND, 4'd0, word_t'(-1), 4'd0);
      else send_op(FN_APPEND, 4'd0, word_t'(k * 3), 4'd0);
    end
    send_op(FN_APPEND, 4'd0, WORD_MAX, 4'd0);
  endtask

  // Edits and searches on a full list, at both ends of the index range.
  task automatic test_edit_search_at_bounds();
    // The duplicate word: the earlier copy wins, then a later start finds the second.
    send_op(FN_SEARCH, 4'd0,  word_t'(-1), 4'd0);
    send_op(FN_SEARCH, 4'd0,  word_t'(-1), 4'd4);
    // The only copy sits before the start index, so the search misses.
    send_op(FN_SEARCH, 4'd0,  WORD_MIN,    4'd1);
    send_op(FN_SEARCH, 4'd0,  word_t'(45), 4'd15);
    send_op(FN_WRITE,  4'd15, word_t'(32'h5A5A_5A5A), 4'd0);
    send_op(FN_SEARCH, 4'd0,  word_t'(45), 4'd0);
    send_op(FN_DELETE, 4'd0,  word_t'(0),  4'd0);
    // The count is now one short of capacity, so the last index is out of range.
    send_op(FN_DELETE, 4'd15, word_t'(0),  4'd0);
    send_op(FN_WRITE,  4'd15, word_t'(0),  4'd0);
    send_op(FN_CLEAR,  4'd0,  word_t'(0),  4'd0);
    send_op(FN_SEARCH, 4'd0,  word_t'(0),  4'd0);
  endtask

  // Picks a word from a short pool so that duplicates and the extremes come up often.
  function automatic word_t pool_word();
    case ($urandom_range(0, 4))
      0: return word_t'(0);
      1: return word_t'(1);
      2: return word_t'(-1);
      3: return WORD_MIN;
      default: return WORD_MAX;
    endcase
  endfunction

  // Random traffic. Each phase is picked at random to grow or to shrink the list, so that
  // both empty and full are reached again and again. Positions and start indexes
  // mostly land inside the list, and searched words come from it in part.
  task automatic test_random_list_traffic(input int n_ops);
    int         roll;
    bit         grow;
    logic [2:0] fn;
    pos_t       pos;
    pos_t       from;
    word_t      val;
    grow = 1'b1;
    for (int k = 0; k < n_ops; k++) begin
      if (k % 120 == 0) grow = $urandom_range(0, 1);
      roll = $urandom_range(0, 99);
      if (grow) begin
        if (roll < 45) fn = FN_APPEND;
        else if (roll < 57) fn = FN_DELETE;
        else if (roll < 69) fn = FN_WRITE;
        else if (roll < 95) fn = FN_SEARCH;
        else if (roll < 96) fn = FN_CLEAR;
        else fn = 3'($urandom_range(FN_RESERVED_LO, FN_RESERVED_HI));
      end else begin
        if (roll < 15) fn = FN_APPEND;
        else if (roll < 50) fn = FN_DELETE;
        else if (roll < 65) fn = FN_WRITE;
        else if (roll < 95) fn = FN_SEARCH;
        else if (roll < 97) fn = FN_CLEAR;
        else fn = 3'($urandom_range(FN_RESERVED_LO, FN_RESERVED_HI));
      end

      if (shadow_len > 0 && $urandom_range(0, 9) < 8) pos = 4'($urandom_range(0, shadow_len - 1));
      else pos = 4'($urandom_range(0, 15));
      if (shadow_len > 0 && $urandom_range(0, 9) < 8) from = 4'($urandom_range(0, shadow_len - 1));
      else from = 4'($urandom_range(0, 15));

      roll = $urandom_range(0, 9);
      if (roll < 4) val = word_t'($urandom);
      else if (roll < 7 && shadow_len > 0) val = shadow_list[$urandom_range(0, shadow_len - 1)];
      else val = pool_word();

      send_op(fn, pos, val, from);
    end
  endtask

  initial begin
    mismatches  = 0;
    beats_seen  = 0;
    shadow_len  = 0;
    burst_left  = $urandom_range(0, 24);
    rst         <= 1'b1;
    start       <= 1'b0;
    func        <= '0;
    position    <= '0;
    value       <= '0;
    start_index <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_list_ops();
    test_fill_to_capacity();
    test_edit_search_at_bounds();
    test_random_list_traffic(RANDOM_OPS);
    start <= 1'b0;

    // Drain, then keep the clock running on so that a stray extra beat
    // would still be caught.
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/ale_pkg.sv
rtl/ale_cell.sv
rtl/ale_result.sv
rtl/array_list_engine.sv
dv/array_list_engine_tb.sv
